// ----- design/calendar_time_setter_unit_defines.svh -----
// Assertion macros for the calendar time setter checker.
`ifndef CALENDAR_TIME_SETTER_UNIT_DEFINES_SVH
`define CALENDAR_TIME_SETTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/cts_pkg.sv -----
// Types, codes and date helpers for the calendar time setter.
package cts_pkg;

    localparam logic [11:0] YEAR_MIN   = 12'd2000;
    localparam logic [11:0] YEAR_MAX   = 12'd2069;
    localparam logic [3:0]  MONTH_MAX  = 4'd12;
    localparam logic [4:0]  HOUR_MAX   = 5'd23;
    localparam logic [5:0]  MINSEC_MAX = 6'd59;
    localparam logic [2:0]  FIELD_LAST = 3'd5;

    localparam logic [2:0] MODE_LEFT  = 3'd0;
    localparam logic [2:0] MODE_RIGHT = 3'd1;
    localparam logic [2:0] MODE_UP    = 3'd2;
    localparam logic [2:0] MODE_DOWN  = 3'd3;
    localparam logic [2:0] MODE_LOAD  = 3'd4;

    localparam logic [1:0] PRESS_SHORT  = 2'd0;
    localparam logic [1:0] PRESS_REPEAT = 2'd1;

    localparam logic [2:0] FIELD_DAY    = 3'd0;
    localparam logic [2:0] FIELD_MONTH  = 3'd1;
    localparam logic [2:0] FIELD_YEAR   = 3'd2;
    localparam logic [2:0] FIELD_HOUR   = 3'd3;
    localparam logic [2:0] FIELD_MINUTE = 3'd4;
    localparam logic [2:0] FIELD_SECOND = 3'd5;

    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  sel;
    } t_state;

    typedef struct packed {
        logic [2:0]  mode;
        logic [1:0]  press_kind;
        logic [11:0] load_year;
        logic [3:0]  load_month;
        logic [4:0]  load_day;
        logic [4:0]  load_hour;
        logic [5:0]  load_minute;
        logic [5:0]  load_second;
    } t_item;

    function automatic logic [4:0] month_length(input logic [3:0] m, input logic [1:0] ylow);
        logic [4:0] len;
        if (m == MONTH_FEB) begin
            len = (ylow == 2'd0) ? 5'd29 : 5'd28;
        end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
            len = 5'd30;
        end else begin
            len = 5'd31;
        end
        return len;
    endfunction

    function automatic logic [4:0] clamp_day(input logic [4:0] d, input logic [3:0] m,
                                             input logic [1:0] ylow);
        logic [4:0] top;
        logic [4:0] res;
        top = month_length(m, ylow);
        if (d == 5'd0) begin
            res = 5'd1;
        end else if (d > top) begin
            res = top;
        end else begin
            res = d;
        end
        return res;
    endfunction

    // up: v >= hi wraps to lo; down: v <= lo wraps to hi
    function automatic logic [11:0] wrap_step(input logic [11:0] v, input logic [11:0] lo,
                                              input logic [11:0] hi, input logic up);
        logic [11:0] res;
        if (up) begin
            res = (v >= hi) ? lo : v + 12'd1;
        end else begin
            res = (v <= lo) ? hi : v - 12'd1;
        end
        return res;
    endfunction

endpackage

// ----- design/cts_step.sv -----
// Next-state logic: applies one button or load beat to the current date and time.
module cts_step import cts_pkg::*; (
    input  t_state i_state,
    input  t_item  i_item,
    output t_state o_state,
    output logic   o_consumed
);

    logic        acting;
    logic        up;
    logic [11:0] yr;
    logic [3:0]  mon;
    logic [4:0]  mlen;

    always_comb begin
        o_state    = i_state;
        o_consumed = 1'b0;
        acting     = (i_item.press_kind == PRESS_SHORT) || (i_item.press_kind == PRESS_REPEAT);
        up         = (i_item.mode == MODE_UP);
        yr         = i_state.year;
        mon        = i_state.month;
        mlen       = month_length(i_state.month, i_state.year[1:0]);

        case (i_item.mode)
            MODE_LOAD: begin
                if (i_item.load_year < YEAR_MIN) begin
                    yr = YEAR_MIN;
                end else if (i_item.load_year > YEAR_MAX) begin
                    yr = YEAR_MAX;
                end else begin
                    yr = i_item.load_year;
                end
                if (i_item.load_month == 4'd0) begin
                    mon = 4'd1;
                end else if (i_item.load_month > MONTH_MAX) begin
                    mon = MONTH_MAX;
                end else begin
                    mon = i_item.load_month;
                end
                o_state.year   = yr;
                o_state.month  = mon;
                o_state.day    = clamp_day(i_item.load_day, mon, yr[1:0]);
                o_state.hour   = i_item.load_hour;
                o_state.minute = i_item.load_minute;
                o_state.second = i_item.load_second;
                o_state.sel    = FIELD_DAY;
                o_consumed     = 1'b1;
            end
            MODE_LEFT: begin
                if (acting) begin
                    o_state.sel = (i_state.sel != 3'd0 && i_state.sel <= FIELD_LAST)
                                  ? i_state.sel - 3'd1 : FIELD_LAST;
                    o_consumed  = 1'b1;
                end
            end
            MODE_RIGHT: begin
                if (acting) begin
                    o_state.sel = (i_state.sel < FIELD_LAST) ? i_state.sel + 3'd1 : FIELD_DAY;
                    o_consumed  = 1'b1;
                end
            end
            MODE_UP, MODE_DOWN: begin
                if (acting) begin
                    o_consumed = 1'b1;
                    case (i_state.sel)
                        FIELD_DAY: begin
                            o_state.day = 5'(wrap_step({7'd0, i_state.day}, 12'd1,
                                                       {7'd0, mlen}, up));
                        end
                        FIELD_MONTH: begin
                            mon = 4'(wrap_step({8'd0, i_state.month}, 12'd1,
                                               {8'd0, MONTH_MAX}, up));
                            o_state.month = mon;
                            o_state.day   = clamp_day(i_state.day, mon, i_state.year[1:0]);
                        end
                        FIELD_YEAR: begin
                            yr = wrap_step(i_state.year, YEAR_MIN, YEAR_MAX, up);
                            o_state.year = yr;
                            o_state.day  = clamp_day(i_state.day, i_state.month, yr[1:0]);
                        end
                        FIELD_HOUR: begin
                            o_state.hour = 5'(wrap_step({7'd0, i_state.hour}, 12'd0,
                                                        {7'd0, HOUR_MAX}, up));
                        end
                        FIELD_MINUTE: begin
                            o_state.minute = 6'(wrap_step({6'd0, i_state.minute}, 12'd0,
                                                          {6'd0, MINSEC_MAX}, up));
                        end
                        FIELD_SECOND: begin
                            o_state.second = 6'(wrap_step({6'd0, i_state.second}, 12'd0,
                                                          {6'd0, MINSEC_MAX}, up));
                        end
                        default: begin
                            o_consumed = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                o_consumed = 1'b0;
            end
        endcase
    end

endmodule

// ----- design/calendar_time_setter_unit.sv -----
// Top level of the calendar time setter: input register, step logic, result register.
// Usage: takes one beat per clock while the output side is not stalled, and returns one
// result beat per input beat, through the input register and then the result register. The
// date and time live in the result register itself, so the step logic of one cycle sees the
// state left by the beat before it and back-to-back beats never wait on each other. Only a
// stalled output holds up the input register, and while a finished result is still waiting
// the input side can still take one beat into an empty input register. After reset the block
// holds 2000-01-01 00:00:00 with the day field selected.
module calendar_time_setter_unit import cts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_mode,
    input  logic [1:0]  i_press_kind,
    input  logic [11:0] i_load_year,
    input  logic [3:0]  i_load_month,
    input  logic [4:0]  i_load_day,
    input  logic [4:0]  i_load_hour,
    input  logic [5:0]  i_load_minute,
    input  logic [5:0]  i_load_second,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_consumed,
    output logic [11:0] o_cur_year,
    output logic [3:0]  o_cur_month,
    output logic [4:0]  o_cur_day,
    output logic [4:0]  o_cur_hour,
    output logic [5:0]  o_cur_minute,
    output logic [5:0]  o_cur_second,
    output logic [2:0]  o_selected_field
);

    logic   r_in_valid;
    t_item  r_item;
    logic   r_out_valid;
    t_state r_state;
    logic   r_consumed;

    t_state n_state;
    logic   n_consumed;
    logic   advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    cts_step u_step (
        .i_state    (r_state),
        .i_item     (r_item),
        .o_state    (n_state),
        .o_consumed (n_consumed)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_consumed     <= 1'b0;
            r_state.year   <= YEAR_MIN;
            r_state.month  <= 4'd1;
            r_state.day    <= 5'd1;
            r_state.hour   <= 5'd0;
            r_state.minute <= 6'd0;
            r_state.second <= 6'd0;
            r_state.sel    <= FIELD_DAY;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
                r_consumed  <= n_consumed;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.mode        <= i_mode;
            r_item.press_kind  <= i_press_kind;
            r_item.load_year   <= i_load_year;
            r_item.load_month  <= i_load_month;
            r_item.load_day    <= i_load_day;
            r_item.load_hour   <= i_load_hour;
            r_item.load_minute <= i_load_minute;
            r_item.load_second <= i_load_second;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_consumed       = r_consumed;
    assign o_cur_year       = r_state.year;
    assign o_cur_month      = r_state.month;
    assign o_cur_day        = r_state.day;
    assign o_cur_hour       = r_state.hour;
    assign o_cur_minute     = r_state.minute;
    assign o_cur_second     = r_state.second;
    assign o_selected_field = r_state.sel;

endmodule

// ----- design/cts_checker.sv -----
// Port-level checker for the calendar time setter, bound to the top level.
`include "calendar_time_setter_unit_defines.svh"

module cts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [2:0]  i_mode,
    input logic [1:0]  i_press_kind,
    input logic [11:0] i_load_year,
    input logic [3:0]  i_load_month,
    input logic [4:0]  i_load_day,
    input logic [4:0]  i_load_hour,
    input logic [5:0]  i_load_minute,
    input logic [5:0]  i_load_second,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_consumed,
    input logic [11:0] o_cur_year,
    input logic [3:0]  o_cur_month,
    input logic [4:0]  o_cur_day,
    input logic [4:0]  o_cur_hour,
    input logic [5:0]  o_cur_minute,
    input logic [5:0]  o_cur_second,
    input logic [2:0]  o_selected_field
);

    `CTS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable({o_consumed, o_cur_year, o_cur_month, o_cur_day, o_cur_hour, o_cur_minute, o_cur_second, o_selected_field}), "stalled result beat changed")

    `CTS_ASSERT_NOW(a_date_range, i_clk, i_rst_n, o_out_valid, o_cur_year >= 12'd2000 && o_cur_year <= 12'd2069 && o_cur_month != 4'd0 && o_cur_month <= 4'd12 && o_cur_day != 5'd0 && o_selected_field <= 3'd5, "result date or selection out of range")

    `CTS_ASSERT_NOW(a_day_fits_month, i_clk, i_rst_n, o_out_valid, (o_cur_month == 4'd2) ? (o_cur_day <= ((o_cur_year[1:0] == 2'd0) ? 5'd29 : 5'd28)) : ((o_cur_month == 4'd4 || o_cur_month == 4'd6 || o_cur_month == 4'd9 || o_cur_month == 4'd11) ? (o_cur_day <= 5'd30) : 1'b1), "day exceeds month length")

    `CTS_ASSERT_NOW(a_result_has_source, i_clk, i_rst_n, $rose(o_out_valid), $past(i_in_valid && o_in_ready, 2), "result beat without an accepted input beat")

endmodule

bind calendar_time_setter_unit cts_checker u_cts_checker (.*);

// ----- sim/tb_calendar_time_setter_unit.sv -----
// Testbench for calendar_time_setter_unit: directed table plus random beats against a predictor.
`timescale 1ns / 1ps

module tb_calendar_time_setter_unit;
    import cts_pkg::*;

    localparam logic [1:0] PRESS_OTHER   = 2'd2;
    localparam logic [1:0] PRESS_SPARE   = 2'd3;
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    localparam int TARGET_ACTED = 1450;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RESET_CYCLES = 9;

    typedef struct packed {
        logic   consumed;
        t_state st;
    } t_cal_result;

    typedef struct {
        t_item       it;
        bit          typed;
        t_cal_result want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [2:0]  i_mode;
    logic [1:0]  i_press_kind;
    logic [11:0] i_load_year;
    logic [3:0]  i_load_month;
    logic [4:0]  i_load_day;
    logic [4:0]  i_load_hour;
    logic [5:0]  i_load_minute;
    logic [5:0]  i_load_second;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_consumed;
    logic [11:0] o_cur_year;
    logic [3:0]  o_cur_month;
    logic [4:0]  o_cur_day;
    logic [4:0]  o_cur_hour;
    logic [5:0]  o_cur_minute;
    logic [5:0]  o_cur_second;
    logic [2:0]  o_selected_field;

    // predicted calendar state
    logic [11:0] cal_year;
    logic [3:0]  cal_month;
    logic [4:0]  cal_day;
    logic [4:0]  cal_hour;
    logic [5:0]  cal_minute;
    logic [5:0]  cal_second;
    logic [2:0]  cal_sel;

    t_cal_result expected_views[$];
    t_row        plan[$];
    int          mismatches = 0;
    int          cycle_count = 0;
    bit          no_gaps = 1'b0;

    calendar_time_setter_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_mode           (i_mode),
        .i_press_kind     (i_press_kind),
        .i_load_year      (i_load_year),
        .i_load_month     (i_load_month),
        .i_load_day       (i_load_day),
        .i_load_hour      (i_load_hour),
        .i_load_minute    (i_load_minute),
        .i_load_second    (i_load_second),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_consumed       (o_consumed),
        .o_cur_year       (o_cur_year),
        .o_cur_month      (o_cur_month),
        .o_cur_day        (o_cur_day),
        .o_cur_hour       (o_cur_hour),
        .o_cur_minute     (o_cur_minute),
        .o_cur_second     (o_cur_second),
        .o_selected_field (o_selected_field)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [4:0] days_in(input logic [3:0] m, input logic [11:0] y);
        if (m == MONTH_FEB) begin
            return (y[1:0] == 2'd0) ? 5'd29 : 5'd28;
        end
        if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
            return 5'd30;
        end
        return 5'd31;
    endfunction

    function automatic int unsigned roll(input int unsigned v, input int unsigned lo,
                                         input int unsigned hi, input bit up);
        if (up) begin
            return (v >= hi) ? lo : v + 1;
        end
        return (v <= lo) ? hi : v - 1;
    endfunction

    function automatic void fit_date();
        logic [4:0] top;
        if (cal_year < YEAR_MIN) begin
            cal_year = YEAR_MIN;
        end else if (cal_year > YEAR_MAX) begin
            cal_year = YEAR_MAX;
        end
        if (cal_month == 4'd0) begin
            cal_month = 4'd1;
        end else if (cal_month > MONTH_MAX) begin
            cal_month = MONTH_MAX;
        end
        top = days_in(cal_month, cal_year);
        if (cal_day == 5'd0) begin
            cal_day = 5'd1;
        end else if (cal_day > top) begin
            cal_day = top;
        end
    endfunction

    function automatic t_cal_result view(input logic c, input logic [11:0] y,
                                         input logic [3:0] m, input logic [4:0] d,
                                         input logic [4:0] h, input logic [5:0] mi,
                                         input logic [5:0] s, input logic [2:0] sel);
        t_cal_result r;
        r.consumed  = c;
        r.st.year   = y;
        r.st.month  = m;
        r.st.day    = d;
        r.st.hour   = h;
        r.st.minute = mi;
        r.st.second = s;
        r.st.sel    = sel;
        return r;
    endfunction

    function automatic t_cal_result advance_calendar(input t_item it);
        logic acts;
        logic hit;
        bit   up;
        acts = (it.press_kind == PRESS_SHORT || it.press_kind == PRESS_REPEAT);
        hit  = 1'b0;
        up   = (it.mode == MODE_UP);
        if (it.mode == MODE_LOAD) begin
            cal_year   = it.load_year;
            cal_month  = it.load_month;
            cal_day    = it.load_day;
            cal_hour   = it.load_hour;
            cal_minute = it.load_minute;
            cal_second = it.load_second;
            fit_date();
            cal_sel = FIELD_DAY;
            hit = 1'b1;
        end else if (acts && it.mode == MODE_LEFT) begin
            cal_sel = (cal_sel > FIELD_DAY && cal_sel <= FIELD_SECOND) ? cal_sel - 3'd1
                                                                       : FIELD_SECOND;
            hit = 1'b1;
        end else if (acts && it.mode == MODE_RIGHT) begin
            cal_sel = (cal_sel < FIELD_SECOND) ? cal_sel + 3'd1 : FIELD_DAY;
            hit = 1'b1;
        end else if (acts && (it.mode == MODE_UP || it.mode == MODE_DOWN)) begin
            hit = 1'b1;
            case (cal_sel)
                FIELD_DAY: begin
                    cal_day = 5'(roll(32'(cal_day), 1, 32'(days_in(cal_month, cal_year)),
                                      up));
                end
                FIELD_MONTH: begin
                    cal_month = 4'(roll(32'(cal_month), 1, 32'(MONTH_MAX), up));
                    fit_date();
                end
                FIELD_YEAR: begin
                    cal_year = 12'(roll(32'(cal_year), 32'(YEAR_MIN), 32'(YEAR_MAX), up));
                    fit_date();
                end
                FIELD_HOUR: begin
                    cal_hour = 5'(roll(32'(cal_hour), 0, 32'(HOUR_MAX), up));
                end
                FIELD_MINUTE: begin
                    cal_minute = 6'(roll(32'(cal_minute), 0, 32'(MINSEC_MAX), up));
                end
                FIELD_SECOND: begin
                    cal_second = 6'(roll(32'(cal_second), 0, 32'(MINSEC_MAX), up));
                end
                default: begin
                    hit = 1'b0;
                end
            endcase
        end
        return view(hit, cal_year, cal_month, cal_day, cal_hour, cal_minute, cal_second,
                    cal_sel);
    endfunction

    function automatic t_item beat(input logic [2:0] mode, input logic [1:0] kind,
                                   input logic [11:0] y, input logic [3:0] m,
                                   input logic [4:0] d, input logic [4:0] h,
                                   input logic [5:0] mi, input logic [5:0] s);
        t_item it;
        it.mode        = mode;
        it.press_kind  = kind;
        it.load_year   = y;
        it.load_month  = m;
        it.load_day    = d;
        it.load_hour   = h;
        it.load_minute = mi;
        it.load_second = s;
        return it;
    endfunction

    function automatic t_item press(input logic [2:0] mode, input logic [1:0] kind);
        return beat(mode, kind, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    endfunction

    function automatic void add_row(input t_item it, input bit typed, input t_cal_result want);
        t_row r;
        r.it    = it;
        r.typed = typed;
        r.want  = want;
        plan.push_back(r);
    endfunction

    function automatic bit is_acted(input t_item it);
        return it.mode == MODE_LOAD ||
               (it.mode <= MODE_DOWN && it.press_kind <= PRESS_REPEAT);
    endfunction

    // mostly well-formed presses and loads; some ignored presses and unused modes
    function automatic t_item random_beat();
        t_item       it;
        int unsigned pick;
        it.mode        = 3'($urandom_range(MODE_LEFT, MODE_DOWN));
        it.press_kind  = 2'($urandom_range(PRESS_SHORT, PRESS_REPEAT));
        it.load_year   = 12'($urandom_range(0, 4095));
        it.load_month  = 4'($urandom_range(0, 15));
        it.load_day    = 5'($urandom_range(0, 31));
        it.load_hour   = 5'($urandom_range(0, 31));
        it.load_minute = 6'($urandom_range(0, 63));
        it.load_second = 6'($urandom_range(0, 63));
        pick = $urandom_range(0, 99);
        if (pick < 14) begin
            it.mode       = MODE_LOAD;
            it.press_kind = 2'($urandom_range(PRESS_SHORT, PRESS_SPARE));
            if ($urandom_range(0, 3) != 0) begin
                it.load_year = 12'($urandom_range(1996, 2073));
            end
            if ($urandom_range(0, 1) != 0) begin
                it.load_day = 5'($urandom_range(28, 31));
            end
            if ($urandom_range(0, 4) != 0) begin
                it.load_hour   = 5'($urandom_range(0, HOUR_MAX));
                it.load_minute = 6'($urandom_range(0, MINSEC_MAX));
                it.load_second = 6'($urandom_range(0, MINSEC_MAX));
            end
        end else if (pick >= 97) begin
            it.mode       = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
            it.press_kind = 2'($urandom_range(PRESS_SHORT, PRESS_SPARE));
        end else if (pick >= 92) begin
            it.press_kind = 2'($urandom_range(PRESS_OTHER, PRESS_SPARE));
        end
        return it;
    endfunction

    task automatic send_beat(input t_item it, input bit typed, input t_cal_result want);
        int          gap;
        t_cal_result predicted;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_mode        <= it.mode;
        i_press_kind  <= it.press_kind;
        i_load_year   <= it.load_year;
        i_load_month  <= it.load_month;
        i_load_day    <= it.load_day;
        i_load_hour   <= it.load_hour;
        i_load_minute <= it.load_minute;
        i_load_second <= it.load_second;
        i_in_valid    <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = advance_calendar(it);
        expected_views.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_cal_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_views.size() == 0) begin
                $display("%0t: result beat with nothing expected, actual %0d-%0d-%0d sel %0d",
                         $time, o_cur_year, o_cur_month, o_cur_day, o_selected_field);
                mismatches++;
            end else begin
                want = expected_views.pop_front();
                check_field("consumed", 32'(want.consumed), 32'(o_consumed));
                check_field("cur_year", 32'(want.st.year), 32'(o_cur_year));
                check_field("cur_month", 32'(want.st.month), 32'(o_cur_month));
                check_field("cur_day", 32'(want.st.day), 32'(o_cur_day));
                check_field("cur_hour", 32'(want.st.hour), 32'(o_cur_hour));
                check_field("cur_minute", 32'(want.st.minute), 32'(o_cur_minute));
                check_field("cur_second", 32'(want.st.second), 32'(o_cur_second));
                check_field("selected_field", 32'(want.st.sel), 32'(o_selected_field));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random stall before each beat
    initial begin
        int w;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            w = no_gaps ? 0 : $urandom_range(0, 3);
            if (w > 0) begin
                i_out_ready <= 1'b0;
                repeat (w) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    initial begin
        t_cal_result none;
        t_item       item;
        int          acted;
        int          sent;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_out_ready   = 1'b0;
        i_mode        = MODE_LEFT;
        i_press_kind  = PRESS_SHORT;
        i_load_year   = 12'd0;
        i_load_month  = 4'd0;
        i_load_day    = 5'd0;
        i_load_hour   = 5'd0;
        i_load_minute = 6'd0;
        i_load_second = 6'd0;
        cal_year      = YEAR_MIN;
        cal_month     = 4'd1;
        cal_day       = 5'd1;
        cal_hour      = 5'd0;
        cal_minute    = 6'd0;
        cal_second    = 6'd0;
        cal_sel       = FIELD_DAY;
        none          = '0;
        acted         = 0;
        sent          = 0;

        // ignored presses and unused mode leave the reset state; a left press then wraps the selection
        add_row(press(MODE_UP, PRESS_OTHER), 1,
                view(1'b0, YEAR_MIN, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, FIELD_DAY));
        add_row(press(MODE_SPARE_LO, PRESS_SHORT), 1,
                view(1'b0, YEAR_MIN, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, FIELD_DAY));
        add_row(press(MODE_LEFT, PRESS_SPARE), 1,
                view(1'b0, YEAR_MIN, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, FIELD_DAY));
        add_row(press(MODE_LEFT, PRESS_SHORT), 1,
                view(1'b1, YEAR_MIN, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, FIELD_SECOND));
        add_row(press(MODE_UP, PRESS_SHORT), 0, none);
        add_row(press(MODE_DOWN, PRESS_REPEAT), 0, none);
        add_row(press(MODE_DOWN, PRESS_SHORT), 0, none);
        add_row(press(MODE_RIGHT, PRESS_REPEAT), 0, none);
        add_row(press(MODE_DOWN, PRESS_SHORT), 0, none);
        // load at the top of every field, time taken as given
        add_row(beat(MODE_LOAD, PRESS_OTHER, 12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63), 1,
                view(1'b1, YEAR_MAX, MONTH_MAX, 5'd31, 5'd31, 6'd63, 6'd63, FIELD_DAY));
        add_row(press(MODE_UP, PRESS_SHORT), 0, none);
        add_row(press(MODE_LEFT, PRESS_SHORT), 0, none);
        add_row(press(MODE_UP, PRESS_SHORT), 0, none);
        add_row(press(MODE_LEFT, PRESS_SHORT), 0, none);
        add_row(press(MODE_LEFT, PRESS_REPEAT), 0, none);
        add_row(press(MODE_DOWN, PRESS_SHORT), 0, none);
        add_row(beat(MODE_LOAD, PRESS_SHORT, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0), 1,
                view(1'b1, YEAR_MIN, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, FIELD_DAY));
        add_row(beat(MODE_LOAD, PRESS_REPEAT, 12'd2004, 4'd2, 5'd31, 5'd23, 6'd59, 6'd59),
                0, none);
        // month step clamps the day
        add_row(beat(MODE_LOAD, PRESS_SHORT, 12'd2001, 4'd3, 5'd31, 5'd12, 6'd30, 6'd30),
                0, none);
        add_row(press(MODE_RIGHT, PRESS_SHORT), 0, none);
        add_row(press(MODE_DOWN, PRESS_SHORT), 0, none);
        // year step out of a leap year, then wrap both ways
        add_row(beat(MODE_LOAD, PRESS_SHORT, 12'd2068, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0),
                0, none);
        add_row(press(MODE_RIGHT, PRESS_SHORT), 0, none);
        add_row(press(MODE_RIGHT, PRESS_SHORT), 0, none);
        add_row(press(MODE_UP, PRESS_SHORT), 0, none);
        add_row(press(MODE_UP, PRESS_REPEAT), 0, none);
        add_row(press(MODE_DOWN, PRESS_SHORT), 0, none);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[k]) begin
            send_beat(plan[k].it, plan[k].typed, plan[k].want);
        end

        while (acted < TARGET_ACTED) begin
            if (sent % 64 == 0) begin
                no_gaps = ($urandom_range(0, 3) == 0);
            end
            if (sent == 500 || sent == 1200) begin
                i_in_valid <= 1'b0;
                while (expected_views.size() != 0) @(posedge i_clk);
                @(negedge i_clk);
            end
            item = random_beat();
            if (is_acted(item)) begin
                acted++;
            end
            send_beat(item, 1'b0, none);
            sent++;
        end

        i_in_valid <= 1'b0;
        while (expected_views.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
